[hw/rtl/fpvs_pkg.sv]
// Package for the flash program/verify sequencer: widths, codes, reset values
// and the command struct between controller and datapath. No dependencies.
`default_nettype none

package fpvs_pkg;

  localparam int PageBytes = 128;
  localparam int AddrW     = $clog2(PageBytes);
  localparam int IdxW      = 7;
  localparam int ByteW     = 8;
  localparam int PassW     = 10;
  localparam int ShortW    = 6;
  localparam int FuncW     = 2;
  localparam int StatW     = 2;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 10;

  localparam logic [PassW-1:0]  CountMax         = 10'd1023;
  localparam logic [PassW-1:0]  MaxPassesReset   = 10'd1000;
  localparam logic [ShortW-1:0] ShortPassesReset = 6'd6;
  localparam logic [ByteW-1:0]  ShortWidthReset  = 8'd30;
  localparam logic [ByteW-1:0]  LongWidthReset   = 8'd200;

  typedef enum logic [FuncW-1:0] {
    FuncStart  = 2'd0,
    FuncLoad   = 2'd1,
    FuncRead   = 2'd2,
    FuncVerify = 2'd3
  } func_e;

  typedef enum logic [StatW-1:0] {
    StatBusy  = 2'd0,
    StatOk    = 2'd1,
    StatRetry = 2'd2,
    StatFail  = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxPasses   = 3'd0,
    CfgShortPasses = 3'd1,
    CfgShortWidth  = 3'd2,
    CfgLongWidth   = 3'd3,
    CfgExtraWidth  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/fpvs_req_if.sv]
// Request channel of the sequencer: valid/ready and one byte access request.
// Depends on fpvs_pkg.
`default_nettype none

interface fpvs_req_if;
  logic                         valid;
  logic                         ready;
  logic [fpvs_pkg::FuncW-1:0]   func;
  logic [fpvs_pkg::IdxW-1:0]    byte_index;
  logic [fpvs_pkg::ByteW-1:0]   data_in;
  logic                         last_byte;

  modport source (output valid, func, byte_index, data_in, last_byte, input ready);
  modport sink   (input valid, func, byte_index, data_in, last_byte, output ready);
endinterface

`default_nettype wire

[hw/rtl/fpvs_rsp_if.sv]
// Result channel of the sequencer: valid/ready and one result per request.
// Depends on fpvs_pkg.
`default_nettype none

interface fpvs_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [fpvs_pkg::ByteW-1:0]   data_out;
  logic [fpvs_pkg::StatW-1:0]   pass_status;
  logic [fpvs_pkg::ByteW-1:0]   pulse_width;
  logic                         extra_pulse;
  logic [fpvs_pkg::PassW-1:0]   pass_number;

  modport source (output valid, data_out, pass_status, pulse_width, extra_pulse,
                  pass_number, input ready);
  modport sink   (input valid, data_out, pass_status, pulse_width, extra_pulse,
                  pass_number, output ready);
endinterface

`default_nettype wire

[hw/rtl/fpvs_ctrl.sv]
// Controller of the sequencer: takes a request, then commits it once the
// result register is free. Depends on fpvs_pkg.
`default_nettype none

module fpvs_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output fpvs_pkg::cmd_t      cmd_o
);

  typedef enum logic {StIdle, StExec} state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    in_ready_o     = (state_q == StIdle);
    cmd_o.capture  = in_valid_i && in_ready_o;
    cmd_o.commit   = (state_q == StExec) && (!out_valid_q || out_ready_i);
    state_d        = state_q;
    out_valid_d    = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (cmd_o.capture) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (cmd_o.commit) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[hw/rtl/fpvs_datapath.sv]
// Datapath of the sequencer: source and reprogram stores, pass state,
// configuration registers and the result register. Depends on fpvs_pkg.
`default_nettype none

module fpvs_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire fpvs_pkg::cmd_t                    cmd_i,
  input  wire logic [fpvs_pkg::FuncW-1:0]        func_i,
  input  wire logic [fpvs_pkg::IdxW-1:0]         byte_index_i,
  input  wire logic [fpvs_pkg::ByteW-1:0]        data_in_i,
  input  wire logic                              last_byte_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [fpvs_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [fpvs_pkg::CfgDataW-1:0]     cfg_wdata_i,
  output logic [fpvs_pkg::ByteW-1:0]             data_out_o,
  output logic [fpvs_pkg::StatW-1:0]             pass_status_o,
  output logic [fpvs_pkg::ByteW-1:0]             pulse_width_o,
  output logic                                   extra_pulse_o,
  output logic [fpvs_pkg::PassW-1:0]             pass_number_o
);

  localparam int AddrW = fpvs_pkg::AddrW;
  localparam int ByteW = fpvs_pkg::ByteW;
  localparam int PassW = fpvs_pkg::PassW;

  logic [ByteW-1:0] src_mem [fpvs_pkg::PageBytes];
  logic [ByteW-1:0] rep_mem [fpvs_pkg::PageBytes];

  // captured request
  fpvs_pkg::func_e  func_q;
  logic [AddrW-1:0] addr_q;
  logic             in_page_q;
  logic [ByteW-1:0] data_q;
  logic             last_q;
  logic [ByteW-1:0] src_rd_q, rep_rd_q;

  // configuration
  logic [PassW-1:0]            max_passes_q;
  logic [fpvs_pkg::ShortW-1:0] short_passes_q;
  logic [ByteW-1:0]            short_width_q, long_width_q;

  // pass state
  logic [PassW-1:0]  pass_q, pass_d;
  logic              matched_q, matched_d;
  fpvs_pkg::status_e status_q, status_d;

  logic [ByteW-1:0] src_b, old_b, dout, rep_wdata;
  logic [PassW-1:0] next_cnt;
  logic             extra, src_we, rep_we, matched_now;
  logic [AddrW-1:0] addr_in;
  logic             in_page_in;

  assign addr_in    = AddrW'(byte_index_i);
  assign in_page_in = (32'(byte_index_i) < 32'(fpvs_pkg::PageBytes));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q    <= fpvs_pkg::func_e'(func_i);
      addr_q    <= addr_in;
      in_page_q <= in_page_in;
      data_q    <= data_in_i;
      last_q    <= last_byte_i;
      src_rd_q  <= src_mem[addr_in];
      rep_rd_q  <= rep_mem[addr_in];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && src_we) begin
      src_mem[addr_q] <= data_q;
    end
    if (cmd_i.commit && rep_we) begin
      rep_mem[addr_q] <= rep_wdata;
    end
  end

  // bytes beyond the page read as zero
  assign src_b = in_page_q ? src_rd_q : '0;
  assign old_b = in_page_q ? rep_rd_q : '0;

  always_comb begin
    pass_d      = pass_q;
    matched_d   = matched_q;
    status_d    = status_q;
    dout        = '0;
    extra       = 1'b0;
    src_we      = 1'b0;
    rep_we      = 1'b0;
    rep_wdata   = data_q;
    matched_now = matched_q && (src_b == data_q);
    next_cnt    = (pass_q < fpvs_pkg::CountMax) ? pass_q + PassW'(1) : fpvs_pkg::CountMax;
    unique case (func_q)
      fpvs_pkg::FuncStart: begin
        pass_d    = '0;
        matched_d = 1'b1;
        status_d  = fpvs_pkg::StatBusy;
      end
      fpvs_pkg::FuncLoad: begin
        src_we = in_page_q;
        rep_we = in_page_q;
      end
      fpvs_pkg::FuncRead: begin
        dout = old_b;
      end
      fpvs_pkg::FuncVerify: begin
        dout      = old_b | data_q;
        rep_we    = in_page_q;
        rep_wdata = src_b | ~data_q;
        matched_d = matched_now;
        // a finished page ignores the end-of-pass marker
        if (last_q && status_q != fpvs_pkg::StatOk && status_q != fpvs_pkg::StatFail) begin
          extra     = (pass_q < PassW'(short_passes_q));
          pass_d    = next_cnt;
          matched_d = 1'b1;
          if (matched_now) begin
            status_d = fpvs_pkg::StatOk;
          end else if (next_cnt >= max_passes_q) begin
            status_d = fpvs_pkg::StatFail;
          end else begin
            status_d = fpvs_pkg::StatRetry;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q         <= '0;
      matched_q      <= 1'b1;
      status_q       <= fpvs_pkg::StatBusy;
      max_passes_q   <= fpvs_pkg::MaxPassesReset;
      short_passes_q <= fpvs_pkg::ShortPassesReset;
      short_width_q  <= fpvs_pkg::ShortWidthReset;
      long_width_q   <= fpvs_pkg::LongWidthReset;
    end else begin
      if (cmd_i.commit) begin
        pass_q    <= pass_d;
        matched_q <= matched_d;
        status_q  <= status_d;
      end
      if (cfg_we_i) begin
        unique case (fpvs_pkg::cfg_reg_e'(cfg_idx_i))
          fpvs_pkg::CfgMaxPasses:   max_passes_q   <= cfg_wdata_i;
          fpvs_pkg::CfgShortPasses: short_passes_q <= cfg_wdata_i[fpvs_pkg::ShortW-1:0];
          fpvs_pkg::CfgShortWidth:  short_width_q  <= cfg_wdata_i[ByteW-1:0];
          fpvs_pkg::CfgLongWidth:   long_width_q   <= cfg_wdata_i[ByteW-1:0];
          // extra pulse width is applied by the caller; nothing here uses it
          fpvs_pkg::CfgExtraWidth:  ;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      data_out_o    <= dout;
      pass_status_o <= status_d;
      pulse_width_o <= (pass_d < PassW'(short_passes_q)) ? short_width_q : long_width_q;
      extra_pulse_o <= extra;
      pass_number_o <= pass_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/flash_program_verify_sequencer.sv]
// Flash program/verify sequencer, top level: controller plus datapath.
// A taken request has its store reads registered; its outcome then enters the
// result register on commit, later while the previous result is still held.
// A new request is taken only once the previous one is committed, due to the
// registered store read ahead of the read-modify-write of the reprogram store.
// Reset: pass count and status cleared, match flag set, registers to defaults;
// page stores are undefined until loaded. Depends on fpvs_pkg and the ifs.
`default_nettype none

module flash_program_verify_sequencer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  fpvs_req_if.sink                            in_req,
  fpvs_rsp_if.source                          out_rsp,
  input  wire logic                           cfg_we_i,
  input  wire logic [fpvs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [fpvs_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  fpvs_pkg::cmd_t cmd;
  logic           in_ready, out_valid;

  // Controller: idle until a request arrives, then hold it until the result
  // register can take the outcome. The next request may be taken while the
  // previous result still waits at the output.
  fpvs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_req.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_rsp.ready),
    .cmd_o       (cmd)
  );

  // Datapath: read both stores on capture, compute and write back on commit.
  fpvs_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (in_req.func),
    .byte_index_i  (in_req.byte_index),
    .data_in_i     (in_req.data_in),
    .last_byte_i   (in_req.last_byte),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .data_out_o    (out_rsp.data_out),
    .pass_status_o (out_rsp.pass_status),
    .pulse_width_o (out_rsp.pulse_width),
    .extra_pulse_o (out_rsp.extra_pulse),
    .pass_number_o (out_rsp.pass_number)
  );

  assign in_req.ready  = in_ready;
  assign out_rsp.valid = out_valid;

  // A taken request occupies the block for the following cycle.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("request taken while the previous one is in flight");

  // An extra pulse only comes with the end of a pass, never with busy status.
  a_extra_ends_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_rsp.valid && out_rsp.extra_pulse) |-> (out_rsp.pass_status != fpvs_pkg::StatBusy))
    else $error("extra pulse reported without a pass outcome");

  // A pass that ended has been counted.
  a_extra_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_rsp.valid && out_rsp.extra_pulse) |-> (out_rsp.pass_number != '0))
    else $error("extra pulse reported with a zero pass count");

endmodule

`default_nettype wire
